>>> design/bda_pkg.sv
// Package: shared constants and controller/datapath interface types for the decimal converter
`timescale 1ns / 1ps
package bda_pkg;

  localparam int VALUE_BITS = 64;
  localparam int IN_BITS    = 64;
  localparam int MAX_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = DIGIT_W * MAX_DIGITS;
  localparam int STEP_W     = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int REMAIN_W   = $clog2(MAX_DIGITS + 1);
  localparam int CHAR_W     = 6;
  localparam int TDATA_W    = 8;

  localparam logic [DIGIT_W-1:0] DIGIT_ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ_ADD   = 4'd3;
  localparam logic [1:0]         ASCII_ZERO_HI   = 2'b11;

  typedef struct packed {
    logic load;
    logic step;
    logic skip;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic step_done;
    logic top_zero;
    logic one_left;
    logic out_free;
  } status_t;

endpackage

>>> design/bda_ctrl.sv
// Controller: sequences load, shift-and-add conversion, leading-zero skip and digit output
`timescale 1ns / 1ps
module bda_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bda_pkg::status_t status_i,
  output bda_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSkip = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.step = 1'b1;
        if (status_i.step_done) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (status_i.top_zero && !status_i.one_left) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.one_left) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/bda_datapath.sv
// Datapath: double-dabble shift register, digit counters and the output register
`timescale 1ns / 1ps
module bda_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bda_pkg::cmd_t                    cmd_i,
  output bda_pkg::status_t                 status_o,
  input  logic [bda_pkg::VALUE_BITS-1:0]   value_i,
  output logic                             out_valid_o,
  output logic [bda_pkg::CHAR_W-1:0]       out_char_o,
  output logic                             out_last_o,
  input  logic                             out_ready_i
);

  logic [bda_pkg::VALUE_BITS-1:0] val_q, val_d;
  logic [bda_pkg::BCD_W-1:0]      bcd_q, bcd_d, bcd_adj;
  logic [bda_pkg::STEP_W-1:0]     step_q, step_d;
  logic [bda_pkg::REMAIN_W-1:0]   remain_q, remain_d;
  logic [bda_pkg::DIGIT_W-1:0]    top_digit;
  logic                           out_valid_q, out_valid_d;
  logic [bda_pkg::CHAR_W-1:0]     out_char_q, out_char_d;
  logic                           out_last_q, out_last_d;

  assign top_digit = bcd_q[bda_pkg::BCD_W-1 -: bda_pkg::DIGIT_W];

  always_comb begin
    for (int i = 0; i < bda_pkg::MAX_DIGITS; i++) begin
      if (bcd_q[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] >= bda_pkg::DIGIT_ADJ_LIMIT) begin
        bcd_adj[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] =
          bcd_q[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] + bda_pkg::DIGIT_ADJ_ADD;
      end else begin
        bcd_adj[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] =
          bcd_q[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W];
      end
    end
  end

  assign status_o.step_done = (step_q == bda_pkg::STEP_W'(bda_pkg::VALUE_BITS - 1));
  assign status_o.top_zero  = (top_digit == '0);
  assign status_o.one_left  = (remain_q == bda_pkg::REMAIN_W'(1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    val_d       = val_q;
    bcd_d       = bcd_q;
    step_d      = step_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      val_d    = value_i;
      bcd_d    = '0;
      step_d   = '0;
      remain_d = bda_pkg::REMAIN_W'(bda_pkg::MAX_DIGITS);
    end
    if (cmd_i.step) begin
      bcd_d  = {bcd_adj[bda_pkg::BCD_W-2:0], val_q[bda_pkg::VALUE_BITS-1]};
      val_d  = val_q << 1;
      step_d = step_q + bda_pkg::STEP_W'(1);
    end
    if (cmd_i.skip || cmd_i.emit) begin
      bcd_d    = bcd_q << bda_pkg::DIGIT_W;
      remain_d = remain_q - bda_pkg::REMAIN_W'(1);
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_char_d  = {bda_pkg::ASCII_ZERO_HI, top_digit};
      out_last_d  = status_o.one_left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    bcd_q      <= bcd_d;
    step_q     <= step_d;
    remain_q   <= remain_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

>>> design/binary_to_decimal_ascii_core.sv
// Top level: binary to decimal ASCII converter with stream input and output
`timescale 1ns / 1ps
// Takes one unsigned value per input transaction and sends its decimal digits as ASCII
// characters, most significant first, no leading zeros, zero as a single '0'; tlast marks
// the final digit. One value is converted at a time: a value is loaded, put through
// VALUE_BITS shift-and-add steps in the double-dabble register, its leading zero digits
// (20 less the digit count) are skipped one at a time, the skip phase is left, and then
// its digits are sent one at a time as the consumer takes them. The last digit waits in
// the output register while the next value is already taken in.
module binary_to_decimal_ascii_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bda_pkg::IN_BITS-1:0] s_axis_tdata,  // [63:0] value
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bda_pkg::TDATA_W-1:0] m_axis_tdata,  // [5:0] digit_char, [7:6] zero
  output logic                        m_axis_tlast   // last_digit
);

  bda_pkg::cmd_t                 cmd;
  bda_pkg::status_t              status;
  logic [bda_pkg::CHAR_W-1:0]    out_char;

  bda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bda_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (s_axis_tdata[bda_pkg::VALUE_BITS-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {(bda_pkg::TDATA_W - bda_pkg::CHAR_W)'(0), out_char};

endmodule

>>> design/bda_checker.sv
// Checker: port-level assertions for the converter, bound to the top level
`timescale 1ns / 1ps
module bda_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [bda_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again during conversion");

  a_digit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'h3) && (m_axis_tdata[3:0] <= 4'd9))
    else $error("output character is not a decimal digit");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a digit run");

endmodule

bind binary_to_decimal_ascii_core bda_checker u_bda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
